/* sv/cau_pkg.sv */
package cau_pkg;

  // Operand format
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned FRAC_BITS  = 16;

  // Derived widths
  localparam int unsigned PW  = 2 * DATA_WIDTH;      // full product
  localparam int unsigned QW  = DATA_WIDTH + 1;      // quotient / root bits per cell chain
  localparam int unsigned SHR = QW - FRAC_BITS;      // dividend bits above the cell chain
  localparam int unsigned OPW = 3;

  // Pipeline shape
  localparam int unsigned N_FRONT = 4;
  localparam int unsigned N_CELL  = QW;
  localparam int unsigned N_STAGE = N_FRONT + N_CELL + 1;

  typedef enum logic [OPW-1:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_CONJ = 3'd4,
    OP_MOD  = 3'd5,
    OP_SDIV = 3'd6,
    OP_EQ   = 3'd7
  } op_e;

  // Accepted input beat
  typedef struct packed {
    op_e                   op;
    logic [DATA_WIDTH-1:0] a_re;
    logic [DATA_WIDTH-1:0] a_im;
    logic [DATA_WIDTH-1:0] b_re;
    logic [DATA_WIDTH-1:0] b_im;
  } oper_t;

  // Operands plus raw products
  typedef struct packed {
    op_e                   op;
    logic [DATA_WIDTH-1:0] a_re;
    logic [DATA_WIDTH-1:0] a_im;
    logic [DATA_WIDTH-1:0] b_re;
    logic [DATA_WIDTH-1:0] b_im;
    logic [PW-1:0]         p1;
    logic [PW-1:0]         p2;
    logic [PW-1:0]         p3;
    logic [PW-1:0]         p4;
    logic [PW-1:0]         p5;
    logic [PW-1:0]         p6;
  } prod_t;

  // Simple results plus divider / root operands
  typedef struct packed {
    op_e                   op;
    logic [DATA_WIDTH-1:0] rr;
    logic [DATA_WIDTH-1:0] ri;
    logic                  eq;
    logic                  dz;
    logic                  ov;
    logic                  neg_re;
    logic                  neg_im;
    logic [PW-1:0]         mag_re;
    logic [PW-1:0]         mag_im;
    logic [PW-1:0]         den;
  } comb_t;

  // State handed from cell to cell
  typedef struct packed {
    op_e                   op;
    logic [DATA_WIDTH-1:0] rr;
    logic [DATA_WIDTH-1:0] ri;
    logic                  eq;
    logic                  dz;
    logic                  ov;
    logic                  neg_re;
    logic                  neg_im;
    logic                  big_re;
    logic                  big_im;
    logic [PW-1:0]         den;
    logic [PW-1:0]         rem_re;
    logic [PW-1:0]         rem_im;
    logic [QW-1:0]         dvd_re;
    logic [QW-1:0]         dvd_im;
    logic [QW-1:0]         q_re;
    logic [QW-1:0]         q_im;
    logic [2*QW-1:0]       sq_n;
    logic [QW+1:0]         sq_rem;
    logic [QW-1:0]         sq_root;
  } cell_t;

endpackage

/* sv/complex_arithmetic_unit.sv */
// Complex arithmetic unit on signed Q16.16 operands.
// Input channel: in_valid_i / in_ready_o carry one beat of op_i and the two
// complex operands a and b. Output channel: out_valid_o / out_ready_i carry
// the result parts res_re_o / res_im_o with the is_equal, div_zero and
// overflow flags.
// Ops: add, sub, mul, complex divide, conjugate a, modulus of a, a divided
// by the real b_re, and equality test. Results saturate and flag overflow.
// Stages, in order: input register, product stage, combine stage, divider
// setup, 33 cells each producing one quotient bit of both parts and one bit
// of the square root, and the output register.
// Throughput: one beat per cycle while the receiver takes results; every
// stage has its own valid bit and loads whenever it is empty or the stage
// after it is free or moving. When the receiver stalls, beats pile up
// stage by stage and in_ready_o drops only once all 38 stages hold a beat.
// Reset clears every valid bit; no result is shown until a beat enters.
module complex_arithmetic_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [cau_pkg::OPW-1:0]               op_i,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0] a_re_i,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0] a_im_i,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0] b_re_i,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0] b_im_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [cau_pkg::DATA_WIDTH-1:0] res_re_o,
  output logic signed [cau_pkg::DATA_WIDTH-1:0] res_im_o,
  output logic                                  is_equal_o,
  output logic                                  div_zero_o,
  output logic                                  overflow_o
);

  localparam int unsigned NS = cau_pkg::N_STAGE;
  localparam int unsigned NF = cau_pkg::N_FRONT;
  localparam int unsigned NC = cau_pkg::N_CELL;

  logic [NS-1:0] valid_d, valid_q, vin, ld;
  logic [NS:0]   rdy;

  // Per-stage flow control: a stage takes a beat when it is empty or drains
  assign rdy[NS] = out_ready_i;
  assign vin[0]  = in_valid_i;

  for (genvar k = 0; k < NS; k++) begin : g_flow
    if (k > 0) begin : g_vin
      assign vin[k] = valid_q[k-1];
    end
    assign rdy[k]     = ~valid_q[k] | rdy[k+1];
    assign ld[k]      = rdy[k] & vin[k];
    assign valid_d[k] = rdy[k] ? vin[k] : valid_q[k];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = valid_q[NS-1];

  // Front stages
  cau_pkg::oper_t oper;
  cau_pkg::cell_t chain [NC+1];

  always_comb begin
    oper.op   = cau_pkg::op_e'(op_i);
    oper.a_re = a_re_i;
    oper.a_im = a_im_i;
    oper.b_re = b_re_i;
    oper.b_im = b_im_i;
  end

  cau_front u_front (
    .clk_i  (clk_i),
    .en_i   (ld[NF-1:0]),
    .oper_i (oper),
    .cell_o (chain[0])
  );

  // Divider and square root cells
  for (genvar c = 0; c < NC; c++) begin : g_cell
    cau_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (ld[NF+c]),
      .cell_i (chain[c]),
      .cell_o (chain[c+1])
    );
  end

  // Output register
  cau_back u_back (
    .clk_i      (clk_i),
    .en_i       (ld[NS-1]),
    .cell_i     (chain[NC]),
    .res_re_o   (res_re_o),
    .res_im_o   (res_im_o),
    .is_equal_o (is_equal_o),
    .div_zero_o (div_zero_o),
    .overflow_o (overflow_o)
  );

endmodule

/* sv/cau_front.sv */
module cau_front (
  input  logic                            clk_i,
  input  logic [cau_pkg::N_FRONT-1:0]     en_i,
  input  cau_pkg::oper_t                  oper_i,
  output cau_pkg::cell_t                  cell_o
);

  localparam int unsigned DW = cau_pkg::DATA_WIDTH;
  localparam int unsigned PW = cau_pkg::PW;
  localparam int unsigned QW = cau_pkg::QW;

  // Clamp to the signed result range; top bit flags saturation
  function automatic logic [DW:0] sat_f(input logic signed [PW:0] v);
    logic signed [PW:0] hi;
    logic signed [PW:0] lo;
    hi = {{(PW-DW+2){1'b0}}, {(DW-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      return {1'b1, hi[DW-1:0]};
    end else if (v < lo) begin
      return {1'b1, lo[DW-1:0]};
    end
    return {1'b0, v[DW-1:0]};
  endfunction

  cau_pkg::oper_t s0_q;
  cau_pkg::prod_t s1_d, s1_q;
  cau_pkg::comb_t s2_d, s2_q;
  cau_pkg::cell_t s3_d, s3_q;

  // Register the accepted beat
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s0_q <= oper_i;
    end
  end

  // Form the six products; modulus squares a instead of crossing with b
  logic signed [DW-1:0] ar0, ai0, br0, bi0, x1, x2;
  logic signed [PW-1:0] m1, m2, m3, m4, m5, m6;

  assign ar0 = s0_q.a_re;
  assign ai0 = s0_q.a_im;
  assign br0 = s0_q.b_re;
  assign bi0 = s0_q.b_im;
  assign x1  = (s0_q.op == cau_pkg::OP_MOD) ? ar0 : br0;
  assign x2  = (s0_q.op == cau_pkg::OP_MOD) ? ai0 : bi0;
  assign m1  = ar0 * x1;
  assign m2  = ai0 * x2;
  assign m3  = ar0 * bi0;
  assign m4  = ai0 * br0;
  assign m5  = br0 * br0;
  assign m6  = bi0 * bi0;

  always_comb begin
    s1_d.op   = s0_q.op;
    s1_d.a_re = s0_q.a_re;
    s1_d.a_im = s0_q.a_im;
    s1_d.b_re = s0_q.b_re;
    s1_d.b_im = s0_q.b_im;
    s1_d.p1   = m1;
    s1_d.p2   = m2;
    s1_d.p3   = m3;
    s1_d.p4   = m4;
    s1_d.p5   = m5;
    s1_d.p6   = m6;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      s1_q <= s1_d;
    end
  end

  // Combine products into simple results and divider operands
  logic signed [DW-1:0] ar, ai, br, bi;
  logic signed [PW-1:0] p1, p2, p3, p4;
  logic signed [PW:0]   w1, w2, w3, w4;
  logic signed [DW:0]   sum_re, sum_im, dif_re, dif_im, nai;
  logic signed [DW:0]   br_w, ar_w, ai_w, abr, aar, aai;
  logic signed [PW:0]   dre, mre, mim, nre, nim, anre, anim;
  logic [PW-1:0]        den3, sq;

  assign ar = s1_q.a_re;
  assign ai = s1_q.a_im;
  assign br = s1_q.b_re;
  assign bi = s1_q.b_im;
  assign p1 = s1_q.p1;
  assign p2 = s1_q.p2;
  assign p3 = s1_q.p3;
  assign p4 = s1_q.p4;
  assign w1 = p1;
  assign w2 = p2;
  assign w3 = p3;
  assign w4 = p4;

  assign sum_re = ar + br;
  assign sum_im = ai + bi;
  assign dif_re = ar - br;
  assign dif_im = ai - bi;
  assign nai    = -ai;

  assign dre  = w1 - w2;
  assign mre  = dre >>> cau_pkg::FRAC_BITS;
  assign mim  = (w3 + w4) >>> cau_pkg::FRAC_BITS;
  assign nre  = w1 + w2;
  assign nim  = w4 - w3;
  assign anre = nre[PW] ? -nre : nre;
  assign anim = nim[PW] ? -nim : nim;
  assign den3 = $unsigned(s1_q.p5) + $unsigned(s1_q.p6);
  assign sq   = $unsigned(s1_q.p1) + $unsigned(s1_q.p2);

  assign br_w = br;
  assign ar_w = ar;
  assign ai_w = ai;
  assign abr  = br_w[DW] ? -br_w : br_w;
  assign aar  = ar_w[DW] ? -ar_w : ar_w;
  assign aai  = ai_w[DW] ? -ai_w : ai_w;

  always_comb begin
    logic [DW:0] sa;
    logic [DW:0] sb;
    sa          = '0;
    sb          = '0;
    s2_d        = '0;
    s2_d.op     = s1_q.op;
    case (s1_q.op)
      cau_pkg::OP_ADD: begin
        sa      = sat_f(sum_re);
        sb      = sat_f(sum_im);
        s2_d.rr = sa[DW-1:0];
        s2_d.ri = sb[DW-1:0];
        s2_d.ov = sa[DW] | sb[DW];
      end
      cau_pkg::OP_SUB: begin
        sa      = sat_f(dif_re);
        sb      = sat_f(dif_im);
        s2_d.rr = sa[DW-1:0];
        s2_d.ri = sb[DW-1:0];
        s2_d.ov = sa[DW] | sb[DW];
      end
      cau_pkg::OP_MUL: begin
        sa      = sat_f(mre);
        sb      = sat_f(mim);
        s2_d.rr = sa[DW-1:0];
        s2_d.ri = sb[DW-1:0];
        s2_d.ov = sa[DW] | sb[DW];
      end
      cau_pkg::OP_DIV: begin
        s2_d.dz     = (br == '0) && (bi == '0);
        s2_d.den    = den3;
        s2_d.neg_re = nre[PW];
        s2_d.neg_im = nim[PW];
        s2_d.mag_re = anre[PW-1:0];
        s2_d.mag_im = anim[PW-1:0];
      end
      cau_pkg::OP_CONJ: begin
        sb      = sat_f(nai);
        s2_d.rr = ar;
        s2_d.ri = sb[DW-1:0];
        s2_d.ov = sb[DW];
      end
      cau_pkg::OP_MOD: begin
        s2_d.mag_re = sq;
      end
      cau_pkg::OP_SDIV: begin
        s2_d.dz     = (br == '0);
        s2_d.den    = {{(PW-DW-1){1'b0}}, abr};
        s2_d.neg_re = (ar[DW-1] ^ br[DW-1]) && (ar != '0);
        s2_d.neg_im = (ai[DW-1] ^ br[DW-1]) && (ai != '0);
        s2_d.mag_re = {{(PW-DW-1){1'b0}}, aar};
        s2_d.mag_im = {{(PW-DW-1){1'b0}}, aai};
      end
      cau_pkg::OP_EQ: begin
        s2_d.eq = (ar == br) && (ai == bi);
      end
      default: begin
        s2_d.eq = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      s2_q <= s2_d;
    end
  end

  // Split the dividends between the head remainder and the cell chain
  logic [PW-1:0] hre, him, sre, sim;

  assign hre = s2_q.mag_re >> cau_pkg::SHR;
  assign him = s2_q.mag_im >> cau_pkg::SHR;
  assign sre = s2_q.mag_re << cau_pkg::FRAC_BITS;
  assign sim = s2_q.mag_im << cau_pkg::FRAC_BITS;

  always_comb begin
    s3_d         = '0;
    s3_d.op      = s2_q.op;
    s3_d.rr      = s2_q.rr;
    s3_d.ri      = s2_q.ri;
    s3_d.eq      = s2_q.eq;
    s3_d.dz      = s2_q.dz;
    s3_d.ov      = s2_q.ov;
    s3_d.neg_re  = s2_q.neg_re;
    s3_d.neg_im  = s2_q.neg_im;
    s3_d.big_re  = hre >= s2_q.den;
    s3_d.big_im  = him >= s2_q.den;
    s3_d.den     = s2_q.den;
    s3_d.rem_re  = hre;
    s3_d.rem_im  = him;
    s3_d.dvd_re  = sre[QW-1:0];
    s3_d.dvd_im  = sim[QW-1:0];
    s3_d.sq_n    = {{(2*QW-PW){1'b0}}, s2_q.mag_re};
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      s3_q <= s3_d;
    end
  end

  assign cell_o = s3_q;

endmodule

/* sv/cau_cell.sv */
module cau_cell (
  input  logic           clk_i,
  input  logic           en_i,
  input  cau_pkg::cell_t cell_i,
  output cau_pkg::cell_t cell_o
);

  localparam int unsigned PW = cau_pkg::PW;
  localparam int unsigned QW = cau_pkg::QW;

  cau_pkg::cell_t cell_d, cell_q;

  // One quotient bit for each part and one root bit
  always_comb begin
    logic [PW:0]   rs_re;
    logic [PW:0]   rs_im;
    logic [PW:0]   df_re;
    logic [PW:0]   df_im;
    logic          qb_re;
    logic          qb_im;
    logic [QW+3:0] st;
    logic [QW+3:0] tr;
    logic [QW+3:0] sd;
    cell_d = cell_i;
    rs_re  = {cell_i.rem_re, cell_i.dvd_re[QW-1]};
    rs_im  = {cell_i.rem_im, cell_i.dvd_im[QW-1]};
    df_re  = rs_re - {1'b0, cell_i.den};
    df_im  = rs_im - {1'b0, cell_i.den};
    qb_re  = rs_re >= {1'b0, cell_i.den};
    qb_im  = rs_im >= {1'b0, cell_i.den};
    cell_d.rem_re = qb_re ? df_re[PW-1:0] : rs_re[PW-1:0];
    cell_d.rem_im = qb_im ? df_im[PW-1:0] : rs_im[PW-1:0];
    cell_d.q_re   = {cell_i.q_re[QW-2:0], qb_re};
    cell_d.q_im   = {cell_i.q_im[QW-2:0], qb_im};
    cell_d.dvd_re = cell_i.dvd_re << 1;
    cell_d.dvd_im = cell_i.dvd_im << 1;

    // Bring down two radicand bits and try root*4+1
    st = {cell_i.sq_rem, cell_i.sq_n[2*QW-1 -: 2]};
    tr = {2'b00, cell_i.sq_root, 2'b01};
    sd = st - tr;
    if (st >= tr) begin
      cell_d.sq_rem  = sd[QW+1:0];
      cell_d.sq_root = {cell_i.sq_root[QW-2:0], 1'b1};
    end else begin
      cell_d.sq_rem  = st[QW+1:0];
      cell_d.sq_root = {cell_i.sq_root[QW-2:0], 1'b0};
    end
    cell_d.sq_n = cell_i.sq_n << 2;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

/* sv/cau_back.sv */
module cau_back (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  cau_pkg::cell_t                        cell_i,
  output logic signed [cau_pkg::DATA_WIDTH-1:0] res_re_o,
  output logic signed [cau_pkg::DATA_WIDTH-1:0] res_im_o,
  output logic                                  is_equal_o,
  output logic                                  div_zero_o,
  output logic                                  overflow_o
);

  localparam int unsigned DW = cau_pkg::DATA_WIDTH;
  localparam int unsigned QW = cau_pkg::QW;

  // Clamp a quotient magnitude and apply its sign; top bit flags saturation
  function automatic logic [DW:0] quot_f(input logic neg, input logic big,
                                         input logic [QW-1:0] q);
    logic [QW-1:0] lim;
    logic [QW-1:0] qq;
    logic [QW-1:0] val;
    logic          ov;
    lim = QW'(1) << (DW - 1);
    if (!neg) begin
      lim = lim - QW'(1);
    end
    ov  = big || (q > lim);
    qq  = ov ? lim : q;
    val = neg ? -qq : qq;
    return {ov, val[DW-1:0]};
  endfunction

  logic [DW-1:0] rr_d, ri_d, rr_q, ri_q;
  logic          eq_d, dz_d, ov_d, eq_q, dz_q, ov_q;

  // Pick the result for the opcode
  always_comb begin
    logic [DW:0]   qr;
    logic [DW:0]   qi;
    logic [QW-1:0] smax;
    qr   = quot_f(cell_i.neg_re, cell_i.big_re, cell_i.q_re);
    qi   = quot_f(cell_i.neg_im, cell_i.big_im, cell_i.q_im);
    smax = {2'b00, {(DW-1){1'b1}}};
    rr_d = cell_i.rr;
    ri_d = cell_i.ri;
    eq_d = cell_i.eq;
    dz_d = cell_i.dz;
    ov_d = cell_i.ov;
    case (cell_i.op)
      cau_pkg::OP_DIV, cau_pkg::OP_SDIV: begin
        if (cell_i.dz) begin
          rr_d = '0;
          ri_d = '0;
          ov_d = 1'b0;
        end else begin
          rr_d = qr[DW-1:0];
          ri_d = qi[DW-1:0];
          ov_d = qr[DW] | qi[DW];
        end
      end
      cau_pkg::OP_MOD: begin
        ri_d = '0;
        if (cell_i.sq_root > smax) begin
          rr_d = smax[DW-1:0];
          ov_d = 1'b1;
        end else begin
          rr_d = cell_i.sq_root[DW-1:0];
          ov_d = 1'b0;
        end
      end
      default: begin
        rr_d = cell_i.rr;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rr_q <= rr_d;
      ri_q <= ri_d;
      eq_q <= eq_d;
      dz_q <= dz_d;
      ov_q <= ov_d;
    end
  end

  assign res_re_o   = rr_q;
  assign res_im_o   = ri_q;
  assign is_equal_o = eq_q;
  assign div_zero_o = dz_q;
  assign overflow_o = ov_q;

endmodule

/* sv/cau_checker.sv */
module cau_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_ready_o,
  input logic [cau_pkg::OPW-1:0]               op_i,
  input logic signed [cau_pkg::DATA_WIDTH-1:0] a_re_i,
  input logic signed [cau_pkg::DATA_WIDTH-1:0] a_im_i,
  input logic signed [cau_pkg::DATA_WIDTH-1:0] b_re_i,
  input logic signed [cau_pkg::DATA_WIDTH-1:0] b_im_i,
  input logic                                  out_valid_o,
  input logic                                  out_ready_i,
  input logic signed [cau_pkg::DATA_WIDTH-1:0] res_re_o,
  input logic signed [cau_pkg::DATA_WIDTH-1:0] res_im_o,
  input logic                                  is_equal_o,
  input logic                                  div_zero_o,
  input logic                                  overflow_o
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(res_re_o) &&
    $stable(res_im_o) && $stable(overflow_o))
    else $error("stalled result beat changed");

  // Equality beats carry zero parts and no other flag
  a_eq_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_equal_o |-> res_re_o == '0 && res_im_o == '0 &&
    !div_zero_o && !overflow_o)
    else $error("equality beat with nonzero payload");

  // Zero divisor forces a zero result without saturation
  a_dz_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && div_zero_o |-> res_re_o == '0 && res_im_o == '0 &&
    !overflow_o && !is_equal_o)
    else $error("divide by zero beat with nonzero payload");

  // Nothing leaves right after reset
  a_rst_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !out_valid_o)
    else $error("result beat right after reset");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);
